FILE: sv/vehicle_light_effects_controller_defines.svh
// Assertion helpers shared by the RTL files.
`ifndef VEHICLE_LIGHT_EFFECTS_CONTROLLER_DEFINES_SVH
`define VEHICLE_LIGHT_EFFECTS_CONTROLLER_DEFINES_SVH

// Condition must hold at every clock edge out of reset.
`define VLEC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) \
        else $error("vlec: invariant violated");

// Consequent must hold in the same cycle as the antecedent.
`define VLEC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("vlec: implication violated");

`endif

FILE: sv/vlec_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package vlec_pkg;

    localparam int BLINK_PERIOD_MS  = 500;
    localparam int ANIM_INTERVAL_MS = 50;
    localparam int LED_COUNT        = 16;

    // configuration register indexes
    localparam logic [2:0] REG_HEADLIGHT_ON    = 3'd0;
    localparam logic [2:0] REG_HEADLIGHT_LEVEL = 3'd1;
    localparam logic [2:0] REG_TAILLIGHT_ON    = 3'd2;
    localparam logic [2:0] REG_INDICATOR_MODE  = 3'd3;
    localparam logic [2:0] REG_BASE_RED        = 3'd4;
    localparam logic [2:0] REG_BASE_GREEN      = 3'd5;
    localparam logic [2:0] REG_BASE_BLUE       = 3'd6;
    localparam logic [2:0] REG_ANIM_MODE       = 3'd7;

    // indicator modes
    localparam logic [1:0] IND_NONE   = 2'd0;
    localparam logic [1:0] IND_LEFT   = 2'd1;
    localparam logic [1:0] IND_RIGHT  = 2'd2;
    localparam logic [1:0] IND_HAZARD = 2'd3;

    // animation modes, codes above CHASE hold the duty
    localparam logic [7:0] ANIM_STATIC  = 8'd0;
    localparam logic [7:0] ANIM_BREATH  = 8'd1;
    localparam logic [7:0] ANIM_RAINBOW = 8'd2;
    localparam logic [7:0] ANIM_CHASE   = 8'd3;

    // round(128*sin(k*pi/128)), k = 0..64
    localparam logic [7:0] QUARTER_SINE [65] = '{
        8'd0,   8'd3,   8'd6,   8'd9,   8'd13,  8'd16,  8'd19,  8'd22,
        8'd25,  8'd28,  8'd31,  8'd34,  8'd37,  8'd40,  8'd43,  8'd46,
        8'd49,  8'd52,  8'd55,  8'd58,  8'd60,  8'd63,  8'd66,  8'd68,
        8'd71,  8'd74,  8'd76,  8'd79,  8'd81,  8'd84,  8'd86,  8'd88,
        8'd91,  8'd93,  8'd95,  8'd97,  8'd99,  8'd101, 8'd103, 8'd105,
        8'd106, 8'd108, 8'd110, 8'd111, 8'd113, 8'd114, 8'd116, 8'd117,
        8'd118, 8'd119, 8'd121, 8'd122, 8'd122, 8'd123, 8'd124, 8'd125,
        8'd126, 8'd126, 8'd127, 8'd127, 8'd127, 8'd128, 8'd128, 8'd128,
        8'd128
    };

    // stage 1 -> stage 2
    typedef struct packed {
        logic       adv;
        logic [7:0] mode;
        logic [7:0] step;
        logic       left;
        logic       right;
    } step_beat_t;

    // stage 2 -> stage 3
    typedef struct packed {
        logic       adv;
        logic [7:0] mode;
        logic       left;
        logic       right;
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } color_beat_t;

    // breathing factor, unsigned Q1.8 (0..256)
    function automatic logic [8:0] breath_factor(input logic [7:0] idx);
        logic [5:0] k;
        logic [6:0] sel;
        logic [7:0] s;
        k   = idx[5:0];
        sel = idx[6] ? (7'd64 - {1'b0, k}) : {1'b0, k};
        s   = QUARTER_SINE[sel];
        return idx[7] ? (9'd128 - {1'b0, s}) : (9'd128 + {1'b0, s});
    endfunction

    // floor(x/3) for x <= 765 by reciprocal multiply (683/2048)
    function automatic logic [7:0] div3(input logic [9:0] x);
        logic [19:0] p;
        p = {10'd0, x} * 20'd683;
        return p[18:11];
    endfunction

endpackage

`default_nettype wire

FILE: sv/vehicle_light_effects_controller.sv
// Vehicle light effects controller. Each s_ beat carries the milliseconds
// elapsed since the previous beat and yields exactly one m_ beat with the
// headlight duty, taillight level, both indicator levels and the underglow
// duty after that beat's update. Indicators blink with a 500 ms half period
// in left, right or hazard mode; the underglow animation (static, breathing,
// rainbow, chase over 16 LEDs) advances once per 50 ms of reported time. Both
// timers saturate and drop any excess past their period. The block is a
// three-stage pipeline: timers and animation step update at accept, stage two
// does the sine lookup and one 8x9 multiply per channel (or the rainbow ramp),
// stage three averages the channels into the duty. Beats move from stage one
// to stage two to the output register; a new beat can be accepted every cycle
// unless m_tready stalls the output, and the stages hold independently so input
// keeps flowing while a result waits. Configuration writes take effect at the
// clock edge and must only be issued with no beats in flight.
`timescale 1ns / 1ps
`default_nettype none
`include "vehicle_light_effects_controller_defines.svh"

module vehicle_light_effects_controller
    import vlec_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // config write port
    input  wire logic        cfg_wr_en,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [7:0]  cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [9:0] elapsed_ms, [15:10] zero
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata    // [7:0] headlight_duty, [8] taillight_out,
                                        // [9] left_indicator, [10] right_indicator,
                                        // [18:11] underglow_duty, [23:19] zero
);

    // ---------------- configuration registers ----------------
    logic       headlight_on_reg,  headlight_on_next;
    logic [7:0] headlight_lvl_reg, headlight_lvl_next;
    logic       taillight_on_reg,  taillight_on_next;
    logic [1:0] ind_mode_reg,      ind_mode_next;
    logic [7:0] base_red_reg,      base_red_next;
    logic [7:0] base_green_reg,    base_green_next;
    logic [7:0] base_blue_reg,     base_blue_next;
    logic [7:0] anim_mode_reg,     anim_mode_next;

    // ---------------- working state ----------------
    logic [15:0] blink_timer_reg, blink_timer_next;
    logic        blink_phase_reg, blink_phase_next;
    logic [15:0] anim_timer_reg,  anim_timer_next;
    logic [7:0]  anim_step_reg,   anim_step_next;
    logic [7:0]  glow_reg,        glow_next;

    // ---------------- pipeline ----------------
    logic        p1_valid_reg, p1_valid_next;
    step_beat_t  p1_reg,       p1_next;
    logic        p2_valid_reg, p2_valid_next;
    color_beat_t p2_reg,       p2_next;
    logic        out_valid_reg, out_valid_next;
    logic [23:0] out_data_reg,  out_data_next;

    logic rdy1, rdy2, rdy3;
    logic s_accept;

    // each stage can load when it is empty or its content moves on
    assign rdy3     = !out_valid_reg || m_tready;
    assign rdy2     = !p2_valid_reg || rdy3;
    assign rdy1     = !p1_valid_reg || rdy2;
    assign s_tready = rdy1;
    assign s_accept = s_tvalid && rdy1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // ---------------- stage 1: timers and step ----------------
    logic [9:0]  elapsed;
    logic [16:0] blink_sum, anim_sum;
    logic [15:0] blink_sat, anim_sat;
    logic        blink_hit, anim_hit;
    logic [8:0]  chase_inc;
    logic [7:0]  step_adv;
    logic [9:0]  cfg_color_sum;

    assign elapsed   = s_tdata[9:0];
    assign blink_sum = {1'b0, blink_timer_reg} + {7'd0, elapsed};
    assign blink_sat = blink_sum[16] ? 16'hFFFF : blink_sum[15:0];
    assign blink_hit = blink_sat >= 16'(BLINK_PERIOD_MS);
    assign anim_sum  = {1'b0, anim_timer_reg} + {7'd0, elapsed};
    assign anim_sat  = anim_sum[16] ? 16'hFFFF : anim_sum[15:0];
    assign anim_hit  = anim_sat >= 16'(ANIM_INTERVAL_MS);
    assign chase_inc = {1'b0, anim_step_reg} + 9'd1;

    // step after a tick, by mode
    always_comb begin
        priority if (anim_mode_reg == ANIM_BREATH || anim_mode_reg == ANIM_RAINBOW) begin
            step_adv = anim_step_reg + 8'd1;
        end else if (anim_mode_reg == ANIM_CHASE) begin
            step_adv = (chase_inc >= 9'(LED_COUNT)) ? 8'd0 : chase_inc[7:0];
        end else begin
            step_adv = anim_step_reg;
        end
    end

    // duty for a base color write, with the new channel substituted
    always_comb begin
        cfg_color_sum = {2'd0, (cfg_index == REG_BASE_RED)   ? cfg_wdata : base_red_reg}
                      + {2'd0, (cfg_index == REG_BASE_GREEN) ? cfg_wdata : base_green_reg}
                      + {2'd0, (cfg_index == REG_BASE_BLUE)  ? cfg_wdata : base_blue_reg};
    end

    // ---------------- stage 2: color per mode ----------------
    logic [8:0]  factor;
    logic [16:0] prod_r, prod_g, prod_b;
    logic [2:0]  region;
    logic [7:0]  region_base, region_off, ramp, ramp_inv;

    assign factor = breath_factor(p1_reg.step);
    assign prod_r = {9'd0, base_red_reg}   * {8'd0, factor};
    assign prod_g = {9'd0, base_green_reg} * {8'd0, factor};
    assign prod_b = {9'd0, base_blue_reg}  * {8'd0, factor};

    // six hue regions of 43 steps, the last of 41
    always_comb begin
        priority if (p1_reg.step >= 8'd215) begin
            region = 3'd5;  region_base = 8'd215;
        end else if (p1_reg.step >= 8'd172) begin
            region = 3'd4;  region_base = 8'd172;
        end else if (p1_reg.step >= 8'd129) begin
            region = 3'd3;  region_base = 8'd129;
        end else if (p1_reg.step >= 8'd86) begin
            region = 3'd2;  region_base = 8'd86;
        end else if (p1_reg.step >= 8'd43) begin
            region = 3'd1;  region_base = 8'd43;
        end else begin
            region = 3'd0;  region_base = 8'd0;
        end
    end

    assign region_off = p1_reg.step - region_base;
    assign ramp       = {2'd0, region_off[5:0]} * 8'd6;
    assign ramp_inv   = 8'd255 - ramp;

    always_comb begin
        p2_next       = p2_reg;
        p2_next.adv   = p1_reg.adv;
        p2_next.mode  = p1_reg.mode;
        p2_next.left  = p1_reg.left;
        p2_next.right = p1_reg.right;
        priority if (p1_reg.mode == ANIM_BREATH) begin
            p2_next.red   = prod_r[15:8];
            p2_next.green = prod_g[15:8];
            p2_next.blue  = prod_b[15:8];
        end else if (p1_reg.mode == ANIM_RAINBOW) begin
            unique case (region)
                3'd0: begin
                    p2_next.red = 8'd255; p2_next.green = ramp;     p2_next.blue = 8'd0;
                end
                3'd1: begin
                    p2_next.red = ramp_inv; p2_next.green = 8'd255; p2_next.blue = 8'd0;
                end
                3'd2: begin
                    p2_next.red = 8'd0;   p2_next.green = 8'd255;   p2_next.blue = ramp;
                end
                3'd3: begin
                    p2_next.red = 8'd0;   p2_next.green = ramp_inv; p2_next.blue = 8'd255;
                end
                3'd4: begin
                    p2_next.red = ramp;   p2_next.green = 8'd0;     p2_next.blue = 8'd255;
                end
                default: begin
                    p2_next.red = 8'd255; p2_next.green = 8'd0;     p2_next.blue = ramp_inv;
                end
            endcase
        end else begin
            // chase: full white pulse on LED zero, averages to 255 or 0
            p2_next.red   = (p1_reg.step == 8'd0) ? 8'd255 : 8'd0;
            p2_next.green = p2_next.red;
            p2_next.blue  = p2_next.red;
        end
    end

    // ---------------- stage 3: average into duty ----------------
    logic [9:0] chan_sum;
    logic [7:0] glow_calc;
    logic       glow_upd;
    logic [7:0] glow_out;

    assign chan_sum  = {2'd0, p2_reg.red} + {2'd0, p2_reg.green} + {2'd0, p2_reg.blue};
    assign glow_calc = div3(chan_sum);
    assign glow_upd  = p2_reg.adv && (p2_reg.mode == ANIM_BREATH
                       || p2_reg.mode == ANIM_RAINBOW || p2_reg.mode == ANIM_CHASE);
    assign glow_out  = glow_upd ? glow_calc : glow_reg;

    // ---------------- next state ----------------
    always_comb begin
        headlight_on_next  = headlight_on_reg;
        headlight_lvl_next = headlight_lvl_reg;
        taillight_on_next  = taillight_on_reg;
        ind_mode_next      = ind_mode_reg;
        base_red_next      = base_red_reg;
        base_green_next    = base_green_reg;
        base_blue_next     = base_blue_reg;
        anim_mode_next     = anim_mode_reg;
        blink_timer_next   = blink_timer_reg;
        blink_phase_next   = blink_phase_reg;
        anim_timer_next    = anim_timer_reg;
        anim_step_next     = anim_step_reg;
        glow_next          = glow_reg;

        if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_HEADLIGHT_ON:    headlight_on_next  = cfg_wdata[0];
                REG_HEADLIGHT_LEVEL: headlight_lvl_next = cfg_wdata;
                REG_TAILLIGHT_ON:    taillight_on_next  = cfg_wdata[0];
                REG_INDICATOR_MODE: begin
                    ind_mode_next    = cfg_wdata[1:0];
                    blink_phase_next = 1'b0;
                    blink_timer_next = 16'd0;
                end
                REG_BASE_RED, REG_BASE_GREEN, REG_BASE_BLUE: begin
                    if (cfg_index == REG_BASE_RED)   base_red_next   = cfg_wdata;
                    if (cfg_index == REG_BASE_GREEN) base_green_next = cfg_wdata;
                    if (cfg_index == REG_BASE_BLUE)  base_blue_next  = cfg_wdata;
                    anim_mode_next = ANIM_STATIC;
                    glow_next      = div3(cfg_color_sum);
                end
                REG_ANIM_MODE: begin
                    anim_mode_next  = cfg_wdata;
                    anim_step_next  = 8'd0;
                    anim_timer_next = 16'd0;
                end
                default: ;
            endcase
        end else begin
            if (s_accept) begin
                if (ind_mode_reg != IND_NONE) begin
                    blink_timer_next = blink_hit ? 16'd0 : blink_sat;
                    blink_phase_next = blink_phase_reg ^ blink_hit;
                end
                anim_timer_next = anim_hit ? 16'd0 : anim_sat;
                if (anim_hit) begin
                    anim_step_next = step_adv;
                end
            end
            if (rdy3 && p2_valid_reg) begin
                glow_next = glow_out;
            end
        end
    end

    // ---------------- pipeline advance ----------------
    always_comb begin
        p1_valid_next  = rdy1 ? s_accept : p1_valid_reg;
        p2_valid_next  = rdy2 ? p1_valid_reg : p2_valid_reg;
        out_valid_next = rdy3 ? p2_valid_reg : out_valid_reg;

        p1_next       = p1_reg;
        p1_next.adv   = anim_hit;
        p1_next.mode  = anim_mode_reg;
        p1_next.step  = anim_hit ? step_adv : anim_step_reg;
        p1_next.left  = blink_phase_next
                        && (ind_mode_reg == IND_LEFT || ind_mode_reg == IND_HAZARD);
        p1_next.right = blink_phase_next
                        && (ind_mode_reg == IND_RIGHT || ind_mode_reg == IND_HAZARD);

        out_data_next = {5'd0, glow_out, p2_reg.right, p2_reg.left, taillight_on_reg,
                         headlight_on_reg ? headlight_lvl_reg : 8'd0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            headlight_on_reg  <= 1'b0;
            headlight_lvl_reg <= 8'd255;
            taillight_on_reg  <= 1'b0;
            ind_mode_reg      <= IND_NONE;
            base_red_reg      <= 8'd0;
            base_green_reg    <= 8'd0;
            base_blue_reg     <= 8'd0;
            anim_mode_reg     <= ANIM_STATIC;
            blink_timer_reg   <= 16'd0;
            blink_phase_reg   <= 1'b0;
            anim_timer_reg    <= 16'd0;
            anim_step_reg     <= 8'd0;
            glow_reg          <= 8'd0;
            p1_valid_reg      <= 1'b0;
            p2_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            headlight_on_reg  <= headlight_on_next;
            headlight_lvl_reg <= headlight_lvl_next;
            taillight_on_reg  <= taillight_on_next;
            ind_mode_reg      <= ind_mode_next;
            base_red_reg      <= base_red_next;
            base_green_reg    <= base_green_next;
            base_blue_reg     <= base_blue_next;
            anim_mode_reg     <= anim_mode_next;
            blink_timer_reg   <= blink_timer_next;
            blink_phase_reg   <= blink_phase_next;
            anim_timer_reg    <= anim_timer_next;
            anim_step_reg     <= anim_step_next;
            glow_reg          <= glow_next;
            p1_valid_reg      <= p1_valid_next;
            p2_valid_reg      <= p2_valid_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // payload stages, loaded only when their beat moves in
    always_ff @(posedge aclk) begin
        if (rdy1 && s_accept) begin
            p1_reg <= p1_next;
        end
        if (rdy2 && p1_valid_reg) begin
            p2_reg <= p2_next;
        end
        if (rdy3 && p2_valid_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    // ---------------- assertions ----------------
    // a timer that reaches its period is zeroed in the same update
    `VLEC_ASSERT_ALWAYS(a_blink_timer_bound, blink_timer_reg < 16'(BLINK_PERIOD_MS))
    `VLEC_ASSERT_ALWAYS(a_anim_timer_bound, anim_timer_reg < 16'(ANIM_INTERVAL_MS))
    // with indicators off the phase is never set
    `VLEC_ASSERT_IMP(a_phase_idle, ind_mode_reg == IND_NONE, !blink_phase_reg)
    // chase keeps its step inside the LED string
    `VLEC_ASSERT_IMP(a_chase_step, anim_mode_reg == ANIM_CHASE, {1'b0, anim_step_reg} < 9'(LED_COUNT))

endmodule

`default_nettype wire
